/* rtl/core/cbm_pkg.sv */
// Package for the cartridge bank mapper: transaction structs, kind and region codes
// and the reset contents of the bank register table.
// No dependencies.
`default_nettype none

package cbm_pkg;

    localparam int BANK_DEPTH = 16;
    localparam int BANK_AW    = 4;

    typedef enum logic [1:0] {
        KIND_CPU_WRITE = 2'd0,
        KIND_SCANLINE  = 2'd1,
        KIND_CPU_XLATE = 2'd2,
        KIND_PAT_XLATE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REGION_PRG  = 2'd0,
        REGION_CHR  = 2'd1,
        REGION_WRAM = 2'd2,
        REGION_NONE = 2'd3
    } region_t;

    localparam logic [1:0] CFG_PRG_MASK    = 2'd0;
    localparam logic [1:0] CFG_CHR_MASK    = 2'd1;
    localparam logic [1:0] CFG_RAM_PRESENT = 2'd2;

    localparam int SEL_CHR_1K   = 5;
    localparam int SEL_PRG_SWAP = 6;
    localparam int SEL_CHR_A12  = 7;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  data_value;
        logic [1:0]  tick_steps;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  region;
        logic [20:0] mapped_offset;
        logic        mirror_horizontal;
        logic        irq_line;
    } out_item_t;

    function automatic logic [7:0] bank_reset(input logic [BANK_AW-1:0] idx);
        logic [7:0] v;
        case (idx)
            4'd1:    v = 8'd2;
            4'd2:    v = 8'd4;
            4'd3:    v = 8'd5;
            4'd4:    v = 8'd6;
            4'd5:    v = 8'd7;
            4'd7:    v = 8'd1;
            4'd15:   v = 8'd2;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/cbm_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cartridge_bank_mapper_irq.sv */
// A result passes the bank table read, registered together with the s1 stage register,
// and then the output register before it is presented; a stalled output holds it longer.
// Throughput: one transaction per cycle unless stalled, set by the single bank RAM read.
// The bank table lives in a 16 x 8 RAM with a registered read port.
// Reset is asynchronous and active low; sixteen valid flags make unwritten bank
// entries read as their reset values, so no clearing pass is needed.
`default_nettype none

module cartridge_bank_mapper_irq
    import cbm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item,
    input  wire logic      cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    typedef struct packed {
        logic [1:0]         region;
        logic               use_mask;
        logic               two_k;
        logic               lsb;
        logic [12:0]        low;
        logic               mirror;
        logic               irq;
        logic               hit;
        logic [BANK_AW-1:0] raddr;
    } stage_t;

    logic [7:0] prg_mask_reg;
    logic [7:0] chr_mask_reg;
    logic       ram_present_reg;

    logic [7:0] bank_select_reg, bank_select_next;
    logic       mirror_reg, mirror_next;
    logic [7:0] latch_reg, latch_next;
    logic [7:0] count_reg, count_next;
    logic       enable_reg, enable_next;
    logic       pending_reg, pending_next;

    logic [BANK_DEPTH-1:0] vld_reg;

    logic       s1_vld_reg;
    stage_t     s1_reg, s1_next;
    logic       out_vld_reg;
    out_item_t  out_reg, out_next;

    logic               in_accept;
    logic               s1_move;
    logic               bank_we;
    logic [BANK_AW-1:0] bank_waddr;
    logic [BANK_AW-1:0] bank_raddr;
    logic [7:0]         bank_rdata;

    logic [7:0] cnt_a;
    logic       pend_a;
    logic [2:0] chr_slot;
    logic [1:0] prg_slot;
    logic [7:0] raw_bank;
    logic [7:0] prg_bank;
    logic [7:0] chr_bank;

    assign s1_move   = s1_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !s1_vld_reg || s1_move;
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        bank_select_next = bank_select_reg;
        mirror_next      = mirror_reg;
        latch_next       = latch_reg;
        count_next       = count_reg;
        enable_next      = enable_reg;
        pending_next     = pending_reg;
        bank_we          = 1'b0;
        bank_waddr       = bank_select_reg[3:0];
        bank_raddr       = '0;
        cnt_a            = count_reg;
        pend_a           = pending_reg;
        prg_slot         = in_item.address[14:13];
        chr_slot         = in_item.address[12:10] ^ {bank_select_reg[SEL_CHR_A12], 2'b00};

        s1_next          = '0;
        s1_next.region   = REGION_NONE;

        case (kind_t'(in_item.kind))
            KIND_CPU_WRITE:
            begin
                if (in_item.address[15])
                begin
                    case (in_item.address[14:13])
                        2'd0:
                        begin
                            if (in_item.address[0])
                            begin
                                bank_we = (bank_select_reg[3:0] <= 4'd9)
                                    || (bank_select_reg[3:0] == 4'd15);
                            end
                            else
                            begin
                                bank_select_next = in_item.data_value;
                            end
                        end
                        2'd1:
                        begin
                            if (!in_item.address[0])
                            begin
                                mirror_next = in_item.data_value[0];
                            end
                        end
                        2'd2:
                        begin
                            if (in_item.address[0])
                            begin
                                count_next = '0;
                            end
                            else
                            begin
                                latch_next = in_item.data_value;
                            end
                        end
                        default:
                        begin
                            if (in_item.address[0])
                            begin
                                enable_next = 1'b1;
                            end
                            else
                            begin
                                enable_next  = 1'b0;
                                pending_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            KIND_SCANLINE:
            begin
                if (in_item.tick_steps != 2'd0)
                begin
                    if (count_reg == 8'd0)
                    begin
                        cnt_a = latch_reg;
                    end
                    else
                    begin
                        cnt_a = count_reg - 8'd1;
                        if (cnt_a == 8'd0 && enable_reg)
                        begin
                            pend_a = 1'b1;
                        end
                    end
                end
                count_next   = cnt_a;
                pending_next = pend_a;
                if (in_item.tick_steps[1])
                begin
                    if (cnt_a == 8'd0)
                    begin
                        count_next = latch_reg;
                    end
                    else
                    begin
                        count_next = cnt_a - 8'd1;
                        if (count_next == 8'd0 && enable_reg)
                        begin
                            pending_next = 1'b1;
                        end
                    end
                end
            end
            KIND_CPU_XLATE:
            begin
                s1_next.low = in_item.address[12:0];
                if (in_item.address[15])
                begin
                    s1_next.region = REGION_PRG;
                    case (prg_slot)
                        2'd3:    s1_next.use_mask = 1'b1;
                        2'd1:    bank_raddr = 4'd7;
                        default:
                        begin
                            if ((prg_slot == 2'd0) == bank_select_reg[SEL_PRG_SWAP])
                            begin
                                bank_raddr = 4'd15;
                            end
                            else
                            begin
                                bank_raddr = 4'd6;
                            end
                        end
                    endcase
                end
                else if (in_item.address[14:13] == 2'b11 && ram_present_reg)
                begin
                    s1_next.region = REGION_WRAM;
                end
            end
            default:
            begin
                s1_next.region = REGION_CHR;
                s1_next.low    = {3'b000, in_item.address[9:0]};
                if (chr_slot[2])
                begin
                    bank_raddr = {1'b0, chr_slot} - 4'd2;
                end
                else if (bank_select_reg[SEL_CHR_1K])
                begin
                    case (chr_slot[1:0])
                        2'd0:    bank_raddr = 4'd0;
                        2'd1:    bank_raddr = 4'd8;
                        2'd2:    bank_raddr = 4'd1;
                        default: bank_raddr = 4'd9;
                    endcase
                end
                else
                begin
                    bank_raddr    = {2'b00, chr_slot[2:1]};
                    s1_next.two_k = 1'b1;
                    s1_next.lsb   = chr_slot[0];
                end
            end
        endcase

        s1_next.mirror = mirror_next;
        s1_next.irq    = pending_next;
        s1_next.hit    = vld_reg[bank_raddr];
        s1_next.raddr  = bank_raddr;
    end

    cbm_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_bank_ram (
        .clk   (clk),
        .we    (in_accept && bank_we),
        .waddr (bank_waddr),
        .wdata (in_item.data_value),
        .re    (in_accept),
        .raddr (bank_raddr),
        .rdata (bank_rdata)
    );

    always_comb
    begin
        raw_bank = s1_reg.hit ? bank_rdata : bank_reset(s1_reg.raddr);
        prg_bank = (s1_reg.use_mask ? prg_mask_reg : raw_bank) & prg_mask_reg;
        chr_bank = (s1_reg.two_k ? {raw_bank[7:1], s1_reg.lsb} : raw_bank) & chr_mask_reg;

        out_next                   = '0;
        out_next.region            = s1_reg.region;
        out_next.mirror_horizontal = s1_reg.mirror;
        out_next.irq_line          = s1_reg.irq;
        case (region_t'(s1_reg.region))
            REGION_PRG:  out_next.mapped_offset = {prg_bank, s1_reg.low};
            REGION_CHR:  out_next.mapped_offset = {3'b000, chr_bank, s1_reg.low[9:0]};
            REGION_WRAM: out_next.mapped_offset = {8'd0, s1_reg.low};
            default:     out_next.mapped_offset = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_mask_reg    <= 8'hFF;
            chr_mask_reg    <= 8'hFF;
            ram_present_reg <= 1'b0;
            bank_select_reg <= '0;
            mirror_reg      <= 1'b0;
            latch_reg       <= '0;
            count_reg       <= '0;
            enable_reg      <= 1'b0;
            pending_reg     <= 1'b0;
            vld_reg         <= '0;
            s1_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PRG_MASK:    prg_mask_reg    <= cfg_data;
                    CFG_CHR_MASK:    chr_mask_reg    <= cfg_data;
                    CFG_RAM_PRESENT: ram_present_reg <= cfg_data[0];
                    default:         ;
                endcase
            end
            if (in_accept)
            begin
                bank_select_reg <= bank_select_next;
                mirror_reg      <= mirror_next;
                latch_reg       <= latch_next;
                count_reg       <= count_next;
                enable_reg      <= enable_next;
                pending_reg     <= pending_next;
                if (bank_we)
                begin
                    vld_reg[bank_waddr] <= 1'b1;
                end
            end
            if (in_accept)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_vld_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_move)
        begin
            out_reg <= out_next;
        end
    end

`ifndef ASSERT_OFF
    a_pending_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> enable_reg)
        else $error("Interrupt pending while the interrupt is disabled.");

    a_no_read_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && !s1_move) |-> !in_accept)
        else $error("Bank table read issued while its data was still held.");

    a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && bank_we) |=> vld_reg[$past(bank_waddr)])
        else $error("Bank table entry written but not marked valid.");
`endif

endmodule

`default_nettype wire
